@@ rtl/bmpn_pkg.sv @@
// Shared types and constants for the Box-Muller pixel noise adder.
`timescale 1ns / 1ps
package bmpn_pkg;

  // Configuration register indexes
  localparam logic REG_NOISE_MEAN  = 1'b0;
  localparam logic REG_NOISE_SIGMA = 1'b1;

  // 2 ln 2 in Q16
  localparam logic [16:0] LN2X2_Q16 = 17'd90852;

  // sin(pi/2 x) odd polynomial, Q16, Horner order
  localparam logic [16:0] POLY_C3 = 17'd307;
  localparam logic [16:0] POLY_C2 = 17'd5223;
  localparam logic [16:0] POLY_C1 = 17'd42334;
  localparam logic [16:0] POLY_C0 = 17'd102944;

  typedef struct packed {
    logic [8:0] cos_mag;
    logic       cos_neg;
    logic [8:0] sin_mag;
    logic       sin_neg;
  } bmpn_trig_t;

  // c - (x2 * y) >> 16, all Q16
  function automatic logic [16:0] poly_step(input logic [16:0] c, input logic [16:0] x2,
                                            input logic [16:0] y);
    logic [33:0] prod;
    prod = x2 * y;
    return c - prod[32:16];
  endfunction

endpackage

@@ rtl/bmpn_radius.sv @@
// Radius path: log2 by repeated squaring, -2 ln u1 scaling and pipelined square root.
`timescale 1ns / 1ps
module bmpn_radius #(
  parameter int UNIFORM_BITS = 16,
  parameter int SQRT_BITS    = 11
) (
  input  logic                    clk,
  input  logic                    ce,
  input  logic [UNIFORM_BITS-1:0] k1,
  output logic [SQRT_BITS-1:0]    s
);
  import bmpn_pkg::*;

  localparam int VW      = UNIFORM_BITS + 1;
  localparam int EW      = $clog2(VW);
  localparam int LOG_MAX = UNIFORM_BITS * 256;
  localparam int DW      = $clog2(LOG_MAX + 1);
  localparam int TMAX    = (LOG_MAX * 90852) / 65536;
  localparam int TW      = $clog2(TMAX + 1);
  localparam int SW      = SQRT_BITS;
  localparam int RW      = 2 * SW;

  // normalize: leading-one position and Q30 mantissa
  logic [VW-1:0]    v;
  logic [EW-1:0]    e0;
  logic [VW+29:0]   shv;

  always_comb begin
    v  = {1'b0, k1} + VW'(1);
    e0 = '0;
    for (int i = 0; i < VW; i++) begin
      if (v[i]) e0 = EW'(i);
    end
    shv = {v, 30'b0} >> e0;
  end

  logic [EW-1:0] e_r [0:8];
  logic [30:0]   m_r [0:8];
  logic [7:0]    f_r [0:8];

  always_ff @(posedge clk) begin
    if (ce) begin
      e_r[0] <= e0;
      m_r[0] <= shv[30:0];
      f_r[0] <= '0;
    end
  end

  genvar j;
  generate
    for (j = 1; j <= 8; j++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] hi;
      assign sq = m_r[j-1] * m_r[j-1];
      assign hi = sq[61:30];
      always_ff @(posedge clk) begin
        if (ce) begin
          e_r[j] <= e_r[j-1];
          m_r[j] <= hi[31] ? hi[31:1] : hi[30:0];
          f_r[j] <= {f_r[j-1][6:0], hi[31]};
        end
      end
    end
  endgenerate

  // t = (LOG_MAX - L8) * 2ln2 >> 16
  logic [DW-1:0]    d;
  logic [DW+16:0]   tprod;
  logic [TW-1:0]    t_r;

  assign d     = DW'(LOG_MAX) - DW'({e_r[8], f_r[8]});
  assign tprod = d * LN2X2_Q16;

  always_ff @(posedge clk) begin
    if (ce) t_r <= tprod[16 +: TW];
  end

  // digit-by-digit square root, one result bit per stage
  logic [SW:0]   rem_w  [0:SW];
  logic [SW-1:0] root_w [0:SW];
  logic [RW-1:0] rad_w  [0:SW];

  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign rad_w[0]  = RW'({t_r, 8'b0});

  genvar i;
  generate
    for (i = 0; i < SW; i++) begin : g_sqrt
      logic [SW+2:0] remx;
      logic [SW+2:0] trial;
      logic          take;
      logic [SW:0]   rem_r;
      logic [SW-1:0] root_r;
      logic [RW-1:0] rad_r;
      assign remx  = {rem_w[i], rad_w[i][RW-1 -: 2]};
      assign trial = {1'b0, root_w[i], 2'b01};
      assign take  = remx >= trial;
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r  <= take ? (SW+1)'(remx - trial) : remx[SW:0];
          root_r <= {root_w[i][SW-2:0], take};
          rad_r  <= {rad_w[i][RW-3:0], 2'b00};
        end
      end
      assign rem_w[i+1]  = rem_r;
      assign root_w[i+1] = root_r;
      assign rad_w[i+1]  = rad_r;
    end
  endgenerate

  assign s = root_w[SW];

endmodule

@@ rtl/bmpn_trig.sv @@
// Angle path: quadrant split, quarter-sine polynomial and cos/sin selection.
`timescale 1ns / 1ps
module bmpn_trig #(
  parameter int UNIFORM_BITS = 16
) (
  input  logic                    clk,
  input  logic                    ce,
  input  logic [UNIFORM_BITS-1:0] k2,
  output bmpn_pkg::bmpn_trig_t    trig
);
  import bmpn_pkg::*;

  logic [15:0] p;
  generate
    if (UNIFORM_BITS >= 16) begin : g_wide
      assign p = k2[UNIFORM_BITS-1 -: 16];
    end else begin : g_narrow
      assign p = {k2, {(16-UNIFORM_BITS){1'b0}}};
    end
  endgenerate

  logic [16:0] xa0, xb0;
  assign xa0 = {1'b0, p[13:0], 2'b00};
  assign xb0 = 17'd65536 - xa0;

  logic [1:0]  q1_r, q2_r, q3_r, q4_r;
  logic [16:0] xa1_r, xb1_r, xa2_r, xb2_r, xa3_r, xb3_r, xa4_r, xb4_r;
  logic [16:0] x2a2_r, x2b2_r, x2a3_r, x2b3_r, x2a4_r, x2b4_r;
  logic [16:0] ya3_r, yb3_r, ya4_r, yb4_r, ya5_r, yb5_r;
  logic [1:0]  q5_r;
  logic [16:0] xa5_r, xb5_r;

  logic [33:0] sqa, sqb;
  assign sqa = xa1_r * xa1_r;
  assign sqb = xb1_r * xb1_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      q1_r   <= p[15:14];
      xa1_r  <= xa0;
      xb1_r  <= xb0;
      q2_r   <= q1_r;
      xa2_r  <= xa1_r;
      xb2_r  <= xb1_r;
      x2a2_r <= sqa[32:16];
      x2b2_r <= sqb[32:16];
      q3_r   <= q2_r;
      xa3_r  <= xa2_r;
      xb3_r  <= xb2_r;
      x2a3_r <= x2a2_r;
      x2b3_r <= x2b2_r;
      ya3_r  <= poly_step(POLY_C2, x2a2_r, POLY_C3);
      yb3_r  <= poly_step(POLY_C2, x2b2_r, POLY_C3);
      q4_r   <= q3_r;
      xa4_r  <= xa3_r;
      xb4_r  <= xb3_r;
      x2a4_r <= x2a3_r;
      x2b4_r <= x2b3_r;
      ya4_r  <= poly_step(POLY_C1, x2a3_r, ya3_r);
      yb4_r  <= poly_step(POLY_C1, x2b3_r, yb3_r);
      q5_r   <= q4_r;
      xa5_r  <= xa4_r;
      xb5_r  <= xb4_r;
      ya5_r  <= poly_step(POLY_C0, x2a4_r, ya4_r);
      yb5_r  <= poly_step(POLY_C0, x2b4_r, yb4_r);
    end
  end

  logic [33:0] fa, fb;
  logic [8:0]  sa, sb;
  bmpn_trig_t  trig_nxt;
  assign fa = xa5_r * ya5_r;
  assign fb = xb5_r * yb5_r;
  assign sa = fa[32:24];
  assign sb = fb[32:24];

  always_comb begin
    case (q5_r)
      2'd0: trig_nxt = '{cos_mag: sb, cos_neg: 1'b0, sin_mag: sa, sin_neg: 1'b0};
      2'd1: trig_nxt = '{cos_mag: sa, cos_neg: 1'b1, sin_mag: sb, sin_neg: 1'b0};
      2'd2: trig_nxt = '{cos_mag: sb, cos_neg: 1'b1, sin_mag: sa, sin_neg: 1'b1};
      default: trig_nxt = '{cos_mag: sa, cos_neg: 1'b0, sin_mag: sb, sin_neg: 1'b1};
    endcase
  end

  bmpn_trig_t trig_r;
  always_ff @(posedge clk) begin
    if (ce) trig_r <= trig_nxt;
  end
  assign trig = trig_r;

endmodule

@@ rtl/box_muller_pixel_noise_adder.sv @@
// Top level: stream ports, configuration, path alignment and noise mixing.
//
// Adds Box-Muller Gaussian noise to pairs of grey pixels.
// Input stream: each request carries two pixels and two uniform codes
//   (radius code and angle code). Output stream: the two noisy pixels.
// Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 = noise mean, 1 = noise sigma); write only while the pipeline is empty.
// Throughput: one pixel pair per cycle when the output is not stalled.
// The pipeline depth is set by the eight squaring stages of the log unit and the
//   one-bit-per-stage square root.
// All stages advance together; when the receiver holds out_tready low with a
//   result pending, the whole pipeline freezes and in_tready drops, so no
//   request is lost or repeated.
// Reset clears the valid chain and both registers to zero; payload registers
//   are not reset. in_tready stays low while reset is held.
`timescale 1ns / 1ps
module box_muller_pixel_noise_adder #(
  parameter int UNIFORM_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // pixel_first, pixel_second, uniform_radius, uniform_angle, zero fill
  input  logic [((16+2*UNIFORM_BITS+7)/8)*8-1:0]      in_tdata,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // noisy_first, noisy_second
  output logic [15:0]                                 out_tdata,
  input  logic                                        cfg_we,
  input  logic                                        cfg_index,
  input  logic [7:0]                                  cfg_data
);
  import bmpn_pkg::*;

  localparam int LOG_MAX = UNIFORM_BITS * 256;
  localparam int TMAX    = (LOG_MAX * 90852) / 65536;
  localparam int TW      = $clog2(TMAX + 1);
  localparam int SW      = (TW + 9) / 2;
  localparam int LR      = 10 + SW;
  localparam int LT      = 6;
  localparam int TD      = LR - LT;
  localparam int LAT     = LR + 3;
  localparam int MW      = 8 + SW;
  localparam int PW      = MW + 9;

  logic [7:0] mean_r, sigma_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= '0;
      sigma_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOISE_MEAN:  mean_r  <= cfg_data;
        REG_NOISE_SIGMA: sigma_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic ce;
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce && rst_n;

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (ce) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end
  assign out_tvalid = vld_r[LAT-1];

  logic [SW-1:0] s;
  bmpn_trig_t    trig;

  bmpn_radius #(.UNIFORM_BITS(UNIFORM_BITS), .SQRT_BITS(SW)) u_radius (
    .clk (clk),
    .ce  (ce),
    .k1  (in_tdata[16 +: UNIFORM_BITS]),
    .s   (s)
  );

  bmpn_trig #(.UNIFORM_BITS(UNIFORM_BITS)) u_trig (
    .clk  (clk),
    .ce   (ce),
    .k2   (in_tdata[16+UNIFORM_BITS +: UNIFORM_BITS]),
    .trig (trig)
  );

  // align pixels and angle terms with the radius path
  logic [15:0] pix_d_r  [0:LR-1];
  bmpn_trig_t  trig_d_r [0:TD-1];
  always_ff @(posedge clk) begin
    if (ce) begin
      pix_d_r[0]  <= in_tdata[15:0];
      trig_d_r[0] <= trig;
      for (int i = 1; i < LR; i++) pix_d_r[i] <= pix_d_r[i-1];
      for (int i = 1; i < TD; i++) trig_d_r[i] <= trig_d_r[i-1];
    end
  end

  logic [MW-1:0] mag_r;
  bmpn_trig_t    trig_a_r;
  logic [15:0]   pix_a_r, pix_b_r;
  logic [PW-1:0] prod_c_r, prod_s_r;
  logic          neg_c_r, neg_s_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      mag_r    <= sigma_r * s;
      trig_a_r <= trig_d_r[TD-1];
      pix_a_r  <= pix_d_r[LR-1];
      prod_c_r <= mag_r * trig_a_r.cos_mag;
      prod_s_r <= mag_r * trig_a_r.sin_mag;
      neg_c_r  <= trig_a_r.cos_neg;
      neg_s_r  <= trig_a_r.sin_neg;
      pix_b_r  <= pix_a_r;
    end
  end

  function automatic logic [7:0] noise_sample(input logic [PW-1:0] prod, input logic neg,
                                              input logic [7:0] mean);
    logic [PW:0] base;
    logic [PW:0] z;
    base = (PW+1)'({mean, 16'b0});
    if (neg) begin
      if ({1'b0, prod} > base) z = '0;
      else z = (base - {1'b0, prod}) >> 16;
    end else begin
      z = (base + {1'b0, prod}) >> 16;
    end
    return (z > (PW+1)'(255)) ? 8'd255 : z[7:0];
  endfunction

  function automatic logic [7:0] add_clamp(input logic [7:0] pix, input logic [7:0] z,
                                           input logic [7:0] mean);
    logic [8:0] sum;
    logic [8:0] dif;
    sum = {1'b0, pix} + {1'b0, z};
    dif = sum - {1'b0, mean};
    if (sum < {1'b0, mean}) return 8'd0;
    return dif[8] ? 8'd255 : dif[7:0];
  endfunction

  logic [15:0] out_tdata_r;
  always_ff @(posedge clk) begin
    if (ce) begin
      out_tdata_r[7:0]  <= add_clamp(pix_b_r[7:0],
                                     noise_sample(prod_c_r, neg_c_r, mean_r), mean_r);
      out_tdata_r[15:8] <= add_clamp(pix_b_r[15:8],
                                     noise_sample(prod_s_r, neg_s_r, mean_r), mean_r);
    end
  end
  assign out_tdata = out_tdata_r;

endmodule
